// ===== rtl/gcd_pkg.sv =====
// shared constants, types and constant functions for the great-circle distance pipeline
package gcd_pkg;

    localparam int F = 30;
    localparam int ITER = F;
    localparam int FIX_W = 34;
    localparam int DEG_W = 26;
    localparam int MAG_W = 23;
    localparam int KF_W = 25;
    localparam int RAD_W = 61;
    localparam int ROOT_W = 31;
    localparam int C_W = 32;
    localparam int ANG_W = 32;
    localparam int RADIUS_W = 16;
    localparam int DIST_W = 18;

    typedef logic signed [FIX_W-1:0] fix_t;

    localparam logic signed [DEG_W:0] HALF_TURN = 27'sd11796480;
    localparam logic signed [DEG_W:0] FULL_TURN = 27'sd23592960;
    localparam logic signed [DEG_W:0] QUARTER_TURN = 27'sd5898240;

    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_GAIN_Q60 = 64'd700114967507363242;
    localparam logic [63:0] K60 = (PI_Q60 + 64'd90) / 64'd180;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd6371;
    localparam logic REG_RADIUS = 1'b0;

    function automatic fix_t q60_to_f(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << (59 - F))) >> (60 - F);
        return fix_t'(r);
    endfunction

    localparam fix_t X0 = q60_to_f(INV_GAIN_Q60);
    localparam fix_t HALF_PI_F = q60_to_f(PI_Q60 / 64'd2);
    localparam fix_t KF_FULL = q60_to_f(K60);
    localparam logic [KF_W-1:0] KF = KF_FULL[KF_W-1:0];

    function automatic fix_t atan_entry(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int e;
        int k;
        acc = 64'd0;
        if (i == 0) begin
            return q60_to_f(PI_Q60 / 64'd4);
        end
        for (k = 0; k < 31; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
                acc = (k % 2 == 1) ? acc - term : acc + term;
            end
        end
        return q60_to_f(acc);
    endfunction

    function automatic fix_t mul30(input fix_t a, input fix_t b);
        logic signed [2*FIX_W-1:0] p;
        p = (a * b + (68'sd1 <<< 29)) >>> 30;
        return p[FIX_W-1:0];
    endfunction

endpackage

// ===== rtl/gcd_rot.sv =====
// angle reduction and rotation-mode cordic giving cosine and sine in q1.30
module gcd_rot
    import gcd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [DEG_W-1:0] in_deg,
    output logic                    out_valid,
    output fix_t                    out_cos,
    output fix_t                    out_sin
);

    logic signed [DEG_W:0] r_fold;
    logic                  cneg_next;
    logic                  neg_next;
    logic [MAG_W-1:0]      mag_next;

    logic                  a_valid_reg;
    logic [MAG_W-1:0]      a_mag_reg;
    logic                  a_neg_reg;
    logic                  a_cneg_reg;

    logic [47:0]           zprod;
    fix_t                  z0_next;

    logic                  v_reg [0:ITER];
    fix_t                  x_reg [0:ITER];
    fix_t                  y_reg [0:ITER];
    fix_t                  z_reg [0:ITER];
    logic                  cn_reg [0:ITER];

    logic                  o_valid_reg;
    fix_t                  o_cos_reg;
    fix_t                  o_sin_reg;

    always_comb begin
        r_fold = {in_deg[DEG_W-1], in_deg};
        cneg_next = 1'b0;
        if (r_fold > HALF_TURN) begin
            r_fold = r_fold - FULL_TURN;
        end else if (r_fold < -HALF_TURN) begin
            r_fold = r_fold + FULL_TURN;
        end
        if (r_fold > QUARTER_TURN) begin
            r_fold = HALF_TURN - r_fold;
            cneg_next = 1'b1;
        end else if (r_fold < -QUARTER_TURN) begin
            r_fold = -HALF_TURN - r_fold;
            cneg_next = 1'b1;
        end
        neg_next = r_fold[DEG_W];
        mag_next = neg_next ? MAG_W'(-r_fold) : MAG_W'(r_fold);
    end

    always_comb begin
        zprod = (48'(a_mag_reg) * 48'(KF) + 48'd32768) >> 16;
        z0_next = a_neg_reg ? -fix_t'(zprod[FIX_W-1:0]) : fix_t'(zprod[FIX_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i <= ITER; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            a_valid_reg <= in_valid;
            v_reg[0] <= a_valid_reg;
            for (int i = 0; i < ITER; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
            o_valid_reg <= v_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg <= mag_next;
            a_neg_reg <= neg_next;
            a_cneg_reg <= cneg_next;
            x_reg[0] <= X0;
            y_reg[0] <= '0;
            z_reg[0] <= z0_next;
            cn_reg[0] <= a_cneg_reg;
            for (int i = 0; i < ITER; i++) begin
                cn_reg[i+1] <= cn_reg[i];
                if (!z_reg[i][FIX_W-1]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end
            end
            o_cos_reg <= cn_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
            o_sin_reg <= y_reg[ITER];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_cos = o_cos_reg;
    assign out_sin = o_sin_reg;

endmodule

// ===== rtl/gcd_isqrt.sv =====
// pipelined integer square root, one result bit per stage
module gcd_isqrt
    import gcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [RAD_W-1:0]      in_rad,
    input  logic signed [C_W-1:0] in_side,
    output logic                  out_valid,
    output logic [ROOT_W-1:0]     out_root,
    output logic signed [C_W-1:0] out_side
);

    localparam int STEPS = ROOT_W;

    logic [RAD_W:0]        v_next   [0:STEPS-1];
    logic [RAD_W:0]        res_next [0:STEPS-1];

    logic                  val_reg  [0:STEPS-1];
    logic [RAD_W:0]        v_reg    [0:STEPS-1];
    logic [RAD_W:0]        res_reg  [0:STEPS-1];
    logic signed [C_W-1:0] side_reg [0:STEPS-1];

    always_comb begin
        logic [RAD_W:0] vin;
        logic [RAD_W:0] rin;
        logic [RAD_W:0] bitv;
        logic [RAD_W:0] t;
        for (int i = 0; i < STEPS; i++) begin
            vin = (i == 0) ? {1'b0, in_rad} : v_reg[(i == 0) ? 0 : i-1];
            rin = (i == 0) ? '0 : res_reg[(i == 0) ? 0 : i-1];
            bitv = (RAD_W+1)'(1) << (2 * (STEPS - 1 - i));
            t = rin + bitv;
            if (vin >= t) begin
                v_next[i] = vin - t;
                res_next[i] = (rin >> 1) + bitv;
            end else begin
                v_next[i] = vin;
                res_next[i] = rin >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STEPS; i++) begin
                val_reg[i] <= 1'b0;
            end
        end else if (en) begin
            val_reg[0] <= in_valid;
            for (int i = 1; i < STEPS; i++) begin
                val_reg[i] <= val_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= in_side;
            for (int i = 0; i < STEPS; i++) begin
                v_reg[i] <= v_next[i];
                res_reg[i] <= res_next[i];
            end
            for (int i = 1; i < STEPS; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = val_reg[STEPS-1];
    assign out_root = res_reg[STEPS-1][ROOT_W-1:0];
    assign out_side = side_reg[STEPS-1];

endmodule

// ===== rtl/gcd_acos.sv =====
// arc cosine through sqrt(1-c*c) and a vectoring cordic
module gcd_acos
    import gcd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [C_W-1:0] in_c,
    output logic                  out_valid,
    output logic [ANG_W-1:0]      out_ang
);

    logic                  s0_valid_reg;
    logic [61:0]           s0_sq_reg;
    logic signed [C_W-1:0] s0_c_reg;
    logic                  s1_valid_reg;
    logic [RAD_W-1:0]      s1_rad_reg;
    logic signed [C_W-1:0] s1_c_reg;

    logic signed [63:0]    sq_full;
    logic [RAD_W-1:0]      rad_next;

    logic                  q_valid;
    logic [ROOT_W-1:0]     q_root;
    logic signed [C_W-1:0] q_c;

    logic                  v_reg [0:ITER];
    fix_t                  x_reg [0:ITER];
    fix_t                  y_reg [0:ITER];
    fix_t                  z_reg [0:ITER];

    logic                  o_valid_reg;
    logic [ANG_W-1:0]      o_ang_reg;

    assign sq_full = in_c * in_c;
    assign rad_next = (s0_sq_reg >= (62'd1 << 60)) ? '0 :
                      RAD_W'((62'd1 << 60) - s0_sq_reg);

    gcd_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s1_valid_reg),
        .in_rad    (s1_rad_reg),
        .in_side   (s1_c_reg),
        .out_valid (q_valid),
        .out_root  (q_root),
        .out_side  (q_c)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            for (int i = 0; i <= ITER; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else if (en) begin
            s0_valid_reg <= in_valid;
            s1_valid_reg <= s0_valid_reg;
            v_reg[0] <= q_valid;
            for (int i = 0; i < ITER; i++) begin
                v_reg[i+1] <= v_reg[i];
            end
            o_valid_reg <= v_reg[ITER];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s0_sq_reg <= sq_full[61:0];
            s0_c_reg <= in_c;
            s1_rad_reg <= rad_next;
            s1_c_reg <= s0_c_reg;
            if (q_c[C_W-1]) begin
                x_reg[0] <= fix_t'({1'b0, q_root});
                y_reg[0] <= -fix_t'(q_c);
                z_reg[0] <= HALF_PI_F;
            end else begin
                x_reg[0] <= fix_t'(q_c);
                y_reg[0] <= fix_t'({1'b0, q_root});
                z_reg[0] <= '0;
            end
            for (int i = 0; i < ITER; i++) begin
                if (y_reg[i] > 0) begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_entry(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_entry(i);
                end
            end
            o_ang_reg <= z_reg[ITER][FIX_W-1] ? '0 : z_reg[ITER][ANG_W-1:0];
        end
    end

    assign out_valid = o_valid_reg;
    assign out_ang = o_ang_reg;

endmodule

// ===== rtl/great_circle_distance.sv =====
// top level: great-circle distance by the spherical law of cosines
//
// Streaming block that takes one pair of points per beat and returns the
// distance in whole kilometres. It accepts a new beat every clock cycle
// while the skid register is empty; the pipeline depth is set mainly by
// the two 30-stage cordic chains and the 31-stage square root chain.
// A stalled output holds the pipeline, with a skid register so that an item in
// flight is never dropped. The earth radius register sits at byte address 0 of
// the apb port and resets to 6371 km; write it only while the block is idle.
module great_circle_distance
    import gcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude[23:0], first_longitude[48:24], second_latitude[72:49],
    // second_longitude[97:73], zero pad
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_km[17:0], zero pad
    output logic [23:0]  m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [RADIUS_W-1:0]   radius_reg;
    logic                  en;
    logic                  in_beat;

    logic signed [DEG_W-1:0] lat1_deg;
    logic signed [DEG_W-1:0] lat2_deg;
    logic signed [DEG_W-1:0] dlon_deg;

    logic                  r_valid;
    fix_t                  c1;
    fix_t                  s1;
    fix_t                  c2;
    fix_t                  s2;
    fix_t                  cd;

    logic                  m1_valid_reg;
    fix_t                  m1_cc_reg;
    fix_t                  m1_ss_reg;
    fix_t                  m1_cd_reg;
    logic                  m2_valid_reg;
    fix_t                  m2_ccc_reg;
    fix_t                  m2_ss_reg;
    logic                  m3_valid_reg;
    logic signed [C_W-1:0] m3_c_reg;

    logic signed [FIX_W:0] sum;
    logic signed [C_W-1:0] c_next;

    logic                  a_valid;
    logic [ANG_W-1:0]      a_ang;
    logic [47:0]           dist_prod;
    logic [DIST_W-1:0]     dist_next;

    logic                  out_valid_reg;
    logic [DIST_W-1:0]     out_dist_reg;
    logic                  skid_valid_reg;
    logic [DIST_W-1:0]     skid_dist_reg;
    logic                  take;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_RADIUS) ? {16'd0, radius_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_RADIUS) begin
            radius_reg <= pwdata[RADIUS_W-1:0];
        end
    end

    assign en = !skid_valid_reg;
    assign s_tready = en;
    assign in_beat = s_tvalid && s_tready;

    assign lat1_deg = DEG_W'($signed(s_tdata[23:0]));
    assign lat2_deg = DEG_W'($signed(s_tdata[72:49]));
    assign dlon_deg = DEG_W'($signed(s_tdata[48:24])) - DEG_W'($signed(s_tdata[97:73]));

    gcd_rot u_rot_lat1 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_beat),
        .in_deg    (lat1_deg),
        .out_valid (r_valid),
        .out_cos   (c1),
        .out_sin   (s1)
    );

    gcd_rot u_rot_lat2 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_beat),
        .in_deg    (lat2_deg),
        .out_valid (),
        .out_cos   (c2),
        .out_sin   (s2)
    );

    gcd_rot u_rot_dlon (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (in_beat),
        .in_deg    (dlon_deg),
        .out_valid (),
        .out_cos   (cd),
        .out_sin   ()
    );

    always_comb begin
        sum = (FIX_W+1)'(m2_ccc_reg) + (FIX_W+1)'(m2_ss_reg);
        if (sum > (35'sd1 <<< 30)) begin
            c_next = 32'sd1 <<< 30;
        end else if (sum < -(35'sd1 <<< 30)) begin
            c_next = -(32'sd1 <<< 30);
        end else begin
            c_next = sum[C_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end else if (en) begin
            m1_valid_reg <= r_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m1_cc_reg <= mul30(c1, c2);
            m1_ss_reg <= mul30(s1, s2);
            m1_cd_reg <= cd;
            m2_ccc_reg <= mul30(m1_cc_reg, m1_cd_reg);
            m2_ss_reg <= m1_ss_reg;
            m3_c_reg <= c_next;
        end
    end

    gcd_acos u_acos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (m3_valid_reg),
        .in_c      (m3_c_reg),
        .out_valid (a_valid),
        .out_ang   (a_ang)
    );

    assign dist_prod = 48'(a_ang) * 48'(radius_reg);
    assign dist_next = dist_prod[F+DIST_W-1:F];

    assign take = out_valid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (a_valid) begin
            if (out_valid_reg && !take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_dist_reg <= skid_dist_reg;
            end
        end else if (a_valid) begin
            if (out_valid_reg && !take) begin
                skid_dist_reg <= dist_next;
            end else begin
                out_dist_reg <= dist_next;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {6'd0, out_dist_reg};

endmodule

// ===== verif/great_circle_distance_tb.sv =====
// testbench for the great-circle distance block: streaming stimulus, cordic predictor, scoreboard
`timescale 1ns / 1ps

module great_circle_distance_tb;
    import gcd_pkg::*;

    localparam int FB = 30;
    localparam longint HALF_DEG = 64'sd11796480;
    localparam longint FULL_DEG = 64'sd23592960;
    localparam longint QUARTER_DEG = 64'sd5898240;
    localparam logic [63:0] PI_Q = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_GAIN_Q = 64'd700114967507363242;
    localparam longint DIST_SAT = 64'sd262143;
    localparam int LAT_MAX = 5898240;
    localparam int LON_MAX = 11796480;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 150;
    localparam logic [2:0] RADIUS_ADDR = 3'(4 * REG_RADIUS);

    class distance_board;
        longint angle_step [FB];
        logic [15:0] radius_km;
        logic [17:0] pending_km [$];
        int mismatches;
        int results_seen;

        function new();
            longint acc;
            longint term;
            int e;
            radius_km = RADIUS_RESET;
            mismatches = 0;
            results_seen = 0;
            angle_step[0] = to_frac(PI_Q / 64'd4);
            for (int i = 1; i < FB; i++) begin
                acc = 0;
                for (int k = 0; k < 31; k++) begin
                    e = i * (2 * k + 1);
                    if (e > 60) break;
                    term = longint'((64'd1 << (60 - e)) / 64'(2 * k + 1));
                    acc = (k % 2 == 1) ? acc - term : acc + term;
                end
                angle_step[i] = to_frac(64'(acc));
            end
        endfunction

        function longint to_frac(logic [63:0] v);
            return longint'((v + (64'd1 << (59 - FB))) >> (60 - FB));
        endfunction

        function longint mul_q30(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        // angle in 2^-16 degree to cos and sin in q1.30
        function void sincos(longint deg, output longint cv, output longint sv);
            longint r, z, x, y, dx, dy;
            logic [63:0] mag, kf;
            bit cneg, neg;
            r = deg % FULL_DEG;
            cneg = 0;
            if (r > HALF_DEG) r -= FULL_DEG;
            if (r < -HALF_DEG) r += FULL_DEG;
            if (r > QUARTER_DEG) begin
                r = HALF_DEG - r;
                cneg = 1;
            end else if (r < -QUARTER_DEG) begin
                r = -HALF_DEG - r;
                cneg = 1;
            end
            neg = r < 0;
            mag = 64'(neg ? -r : r);
            kf = 64'(to_frac((PI_Q + 64'd90) / 64'd180));
            z = longint'((mag * kf + (64'd1 << 15)) >> 16);
            if (neg) z = -z;
            x = to_frac(INV_GAIN_Q);
            y = 0;
            for (int i = 0; i < FB; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= angle_step[i];
                end else begin
                    x += dx; y -= dy; z += angle_step[i];
                end
            end
            cv = cneg ? -x : x;
            sv = y;
        endfunction

        function longint int_sqrt(logic [63:0] v);
            logic [63:0] res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return longint'(res);
        endfunction

        function longint central_angle(longint c);
            logic [63:0] c2;
            longint x, y, z, t, dx, dy;
            c2 = 64'(c * c);
            y = int_sqrt(c2 >= (64'd1 << 60) ? 64'd0 : (64'd1 << 60) - c2);
            x = c;
            z = 0;
            if (x < 0) begin
                t = x;
                x = y;
                y = -t;
                z = to_frac(PI_Q / 64'd2);
            end
            for (int i = 0; i < FB; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx; y -= dy; z += angle_step[i];
                end else begin
                    x -= dx; y += dy; z -= angle_step[i];
                end
            end
            return z < 0 ? 0 : z;
        endfunction

        function logic [17:0] distance_of(logic [97:0] d);
            longint lat1, lon1, lat2, lon2, c1, s1, c2, s2, cd, sd, sum, ang, km_full;
            lat1 = longint'($signed(d[23:0]));
            lon1 = longint'($signed(d[48:24]));
            lat2 = longint'($signed(d[72:49]));
            lon2 = longint'($signed(d[97:73]));
            sincos(lat1, c1, s1);
            sincos(lat2, c2, s2);
            sincos(lon1 - lon2, cd, sd);
            sum = mul_q30(mul_q30(c1, c2), cd) + mul_q30(s1, s2);
            if (sum > (64'sd1 <<< 30)) sum = 64'sd1 <<< 30;
            if (sum < -(64'sd1 <<< 30)) sum = -(64'sd1 <<< 30);
            ang = central_angle(sum);
            km_full = (ang * longint'(radius_km)) >>> FB;
            if (km_full > DIST_SAT) km_full = DIST_SAT;
            return 18'(km_full);
        endfunction

        function void note_pair(logic [97:0] d);
            pending_km.push_back(distance_of(d));
        endfunction

        function void check_distance(logic [17:0] got);
            logic [17:0] want;
            results_seen++;
            if (pending_km.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: distance_km %0d", got);
                return;
            end
            want = pending_km.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("distance_km mismatch: expected %0d, got %0d", want, got);
            end
        endfunction
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [103:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [23:0] m_tdata;
    logic psel = 0;
    logic penable = 0;
    logic pwrite = 0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    distance_board board = new();
    int cycles = 0;
    bit quiet = 0;
    bit hold_request = 0;
    int pairs_sent = 0;

    great_circle_distance dut (.*);

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", board.pending_km.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_distance(m_tdata[17:0]);

    // result side: random stalls, one long hold on request
    initial begin
        int n;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_tready = 0;
                repeat (400) @(negedge aclk);
                hold_request = 0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                m_tready = 0;
                n = $urandom_range(6, 1);
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_tready = 1;
            end
        end
    end

    task automatic send_pair(input int lat1, input int lon1, input int lat2, input int lon2);
        logic [97:0] d;
        int n;
        d = {25'(lon2), 24'(lat2), 25'(lon1), 24'(lat1)};
        @(negedge aclk);
        if (!quiet && $urandom_range(5) == 0) begin
            s_tvalid = 0;
            n = $urandom_range(6, 1);
            repeat (n) @(negedge aclk);
        end
        s_tvalid = 1;
        s_tdata = {6'd0, d};
        do @(posedge aclk); while (!s_tready);
        board.note_pair(d);
        pairs_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (board.pending_km.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_radius(input logic [15:0] km);
        logic [31:0] seen;
        @(negedge aclk);
        psel = 1; pwrite = 1; penable = 0; paddr = RADIUS_ADDR; pwdata = {$urandom} << 16 | km;
        @(negedge aclk);
        penable = 1;
        @(negedge aclk);
        pwrite = 0; penable = 0;
        board.radius_km = km;
        @(negedge aclk);
        penable = 1;
        @(posedge aclk);
        seen = prdata;
        @(negedge aclk);
        psel = 0; penable = 0;
        if (seen[15:0] !== km) begin
            board.mismatches++;
            if (board.mismatches <= 10)
                $display("radius readback: expected %0d, got %0d", km, seen[15:0]);
        end
    endtask

    task automatic send_random(input int count);
        int lat1, lon1, lat2, lon2, mode;
        for (int i = 0; i < count; i++) begin
            mode = $urandom_range(9);
            lat1 = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
            lon1 = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
            lat2 = int'($urandom_range(2 * LAT_MAX)) - LAT_MAX;
            lon2 = int'($urandom_range(2 * LON_MAX)) - LON_MAX;
            if (mode == 0) begin
                lat1 = $urandom; lon1 = $urandom; lat2 = $urandom; lon2 = $urandom;
            end else if (mode <= 2) begin
                // nearby points
                lat2 = lat1 + int'($urandom_range(4000)) - 2000;
                lon2 = lon1 + int'($urandom_range(4000)) - 2000;
            end else if (mode == 3) begin
                // nearly antipodal points
                lat2 = -lat1 + int'($urandom_range(400)) - 200;
                lon2 = lon1 + LON_MAX + int'($urandom_range(400)) - 200;
            end
            send_pair(lat1, lon1, lat2, lon2);
        end
    endtask

    initial begin
        logic [15:0] radii [5];
        radii = '{16'd1, 16'd65535, 16'd0, 16'd6371, 16'd0};
        radii[4] = $urandom_range(65535, 1);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        send_pair(0, 0, 0, 0);
        send_pair(LAT_MAX, 0, -LAT_MAX, 0);
        send_pair(0, LON_MAX, 0, -LON_MAX);
        send_pair(0, 0, 0, LON_MAX);
        send_pair(0, -LON_MAX, 0, 0);
        send_pair(1234567, -7654321, 1234567, -7654321);
        send_pair(0, 0, 0, 1);
        send_pair(LAT_MAX, 3000000, LAT_MAX, -9000000);
        send_pair(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_pair(0, 0, 1, LON_MAX - 1);
        send_pair(24'h7FFFFF, 25'h0FFFFFF, 24'h800000, 25'h1000000);
        send_pair(24'h800000, 25'h1000000, 24'h7FFFFF, 25'h0FFFFFF);
        send_pair(-1, -1, -1, -1);
        send_pair(LAT_MAX / 2, LON_MAX / 2, -LAT_MAX / 2, -LON_MAX / 2);
        send_pair(-LAT_MAX, 0, -LAT_MAX, LON_MAX);
        send_pair(3, -5, -3, 5);
        drain();

        for (int p = 0; p < 5; p++) begin
            write_radius(radii[p]);
            if (p == 1) hold_request = 1;
            if (p == 4) quiet = 1;
            send_random(110);
            drain();
        end

        $display("%0d point pairs sent, %0d results checked over six radius settings",
                 pairs_sent, board.results_seen);
        $display("included pole, antimeridian, antipode and out-of-range angle patterns");
        if (board.mismatches == 0 && board.pending_km.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d results missing", board.mismatches,
                     board.pending_km.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== great_circle_distance.f =====
rtl/gcd_pkg.sv
rtl/gcd_rot.sv
rtl/gcd_isqrt.sv
rtl/gcd_acos.sv
rtl/great_circle_distance.sv
verif/great_circle_distance_tb.sv
